[hw/rtl/ata_pkg.sv]
package ata_pkg;

   // Geometry of the backing store.
   localparam int NUM_SECTORS_DEF  = 64;
   localparam int WORDS_PER_SECTOR = 256;
   localparam int WORD_W           = 8;
   localparam int LBA_W            = 28;
   localparam int COUNT_W          = 9;

   // Task-file port offsets.
   localparam logic [2:0] PORT_DATA    = 3'd0;
   localparam logic [2:0] PORT_ERROR   = 3'd1;
   localparam logic [2:0] PORT_COUNT   = 3'd2;
   localparam logic [2:0] PORT_LBA_LO  = 3'd3;
   localparam logic [2:0] PORT_LBA_MID = 3'd4;
   localparam logic [2:0] PORT_LBA_HI  = 3'd5;
   localparam logic [2:0] PORT_DRIVE   = 3'd6;
   localparam logic [2:0] PORT_STATUS  = 3'd7;

   // Bus actions.
   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   // Commands.
   localparam logic [7:0] CMD_READ  = 8'h20;
   localparam logic [7:0] CMD_WRITE = 8'h30;
   localparam logic [7:0] CMD_FLUSH = 8'hE7;

   // Status bits and error codes.
   localparam logic [7:0] ST_RDY   = 8'h40;
   localparam logic [7:0] ST_DRQ   = 8'h08;
   localparam logic [7:0] ST_ERR   = 8'h01;
   localparam logic [7:0] ERR_NONE = 8'h00;
   localparam logic [7:0] ERR_ABRT = 8'h04;
   localparam logic [7:0] ERR_IDNF = 8'h10;

   // Access strobes toward the sector store.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_cmd_type;

endpackage

[hw/rtl/ata_if.sv]
// Bus access channel: one task-file read or write per transfer.
interface ata_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [2:0]  port_offset;
   logic [15:0] write_data;

   modport source (output valid, output action, output port_offset, output write_data,
                   input ready);
   modport sink   (input valid, input action, input port_offset, input write_data,
                   output ready);
endinterface

// Result channel: one data word per bus access.
interface ata_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_data;

   modport source (output valid, output read_data, input ready);
   modport sink   (input valid, input read_data, output ready);
endinterface

[hw/rtl/ata_sector_store.sv]
module ata_sector_store #(
   parameter int DEPTH  = ata_pkg::NUM_SECTORS_DEF * ata_pkg::WORDS_PER_SECTOR,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  ata_pkg::mem_cmd_type  mem_cmd,
   input  logic [ADDR_W-1:0]     mem_addr,
   input  logic [15:0]           mem_wdata,
   output logic [15:0]           rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   // Single-port synchronous memory; the read word is held until the next read.
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_cmd.rd_en) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/ata_task_file.sv]
module ata_task_file #(
   parameter int NUM_SECTORS = ata_pkg::NUM_SECTORS_DEF,
   parameter int ADDR_W      = $clog2(NUM_SECTORS * ata_pkg::WORDS_PER_SECTOR)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  action,
   input  logic [2:0]            port_offset,
   input  logic [15:0]           write_data,
   output logic [15:0]           reg_data,
   output logic                  use_mem,
   output ata_pkg::mem_cmd_type  mem_cmd,
   output logic [ADDR_W-1:0]     mem_addr,
   output logic [15:0]           mem_wdata
);

   localparam int CS_W = $clog2(NUM_SECTORS + 1);
   localparam int WW   = ata_pkg::WORD_W;
   localparam int CW   = ata_pkg::COUNT_W;
   localparam int LW   = ata_pkg::LBA_W;

   logic [7:0]    count_ff, count_in;
   logic [7:0]    lba_lo_ff, lba_lo_in;
   logic [7:0]    lba_mid_ff, lba_mid_in;
   logic [7:0]    lba_hi_ff, lba_hi_in;
   logic [7:0]    drive_ff, drive_in;
   logic [7:0]    err_reg_ff, err_reg_in;
   logic          drq_ff, drq_in;
   logic          err_flag_ff, err_flag_in;
   logic          writing_ff, writing_in;
   logic [CS_W-1:0] cur_ff, cur_in;
   logic [CW-1:0] left_ff, left_in;
   logic [WW-1:0] word_ff, word_in;

   logic [LW-1:0] lba;
   logic [CW-1:0] count_full;
   logic [LW:0]   range_end;
   logic          past_end;
   logic          in_range;
   logic          advance;
   logic [7:0]    status;
   logic [7:0]    wbyte;

   // Command decode helpers.
   assign lba        = {drive_ff[3:0], lba_hi_ff, lba_mid_ff, lba_lo_ff};
   assign count_full = (count_ff == 8'h00) ? CW'(256) : CW'(count_ff);
   assign range_end  = {1'b0, lba} + (LW+1)'(count_full);
   assign past_end   = range_end > (LW+1)'(NUM_SECTORS);
   assign in_range   = cur_ff < CS_W'(NUM_SECTORS);
   assign status     = ata_pkg::ST_RDY | (drq_ff ? ata_pkg::ST_DRQ : 8'h00)
                       | (err_flag_ff ? ata_pkg::ST_ERR : 8'h00);
   assign wbyte      = write_data[7:0];

   // Store address is the sector number followed by the word index.
   assign mem_addr  = ADDR_W'({cur_ff, word_ff});
   assign mem_wdata = write_data;

   // Access decode and next-state logic.
   always_comb begin
      count_in    = count_ff;
      lba_lo_in   = lba_lo_ff;
      lba_mid_in  = lba_mid_ff;
      lba_hi_in   = lba_hi_ff;
      drive_in    = drive_ff;
      err_reg_in  = err_reg_ff;
      drq_in      = drq_ff;
      err_flag_in = err_flag_ff;
      writing_in  = writing_ff;
      cur_in      = cur_ff;
      left_in     = left_ff;
      word_in     = word_ff;
      reg_data    = 16'h0000;
      use_mem     = 1'b0;
      mem_cmd     = '0;
      advance     = 1'b0;

      if (accept) begin
         if (action == ata_pkg::ACT_READ) begin
            unique case (port_offset)
               ata_pkg::PORT_DATA: begin
                  if (drq_ff && !writing_ff) begin
                     use_mem       = in_range;
                     mem_cmd.rd_en = in_range;
                     advance       = 1'b1;
                  end
               end
               ata_pkg::PORT_ERROR:   reg_data = {8'h00, err_reg_ff};
               ata_pkg::PORT_COUNT:   reg_data = {8'h00, count_ff};
               ata_pkg::PORT_LBA_LO:  reg_data = {8'h00, lba_lo_ff};
               ata_pkg::PORT_LBA_MID: reg_data = {8'h00, lba_mid_ff};
               ata_pkg::PORT_LBA_HI:  reg_data = {8'h00, lba_hi_ff};
               ata_pkg::PORT_DRIVE:   reg_data = {8'h00, drive_ff};
               default:               reg_data = {8'h00, status};
            endcase
         end else begin
            unique case (port_offset)
               ata_pkg::PORT_DATA: begin
                  if (drq_ff && writing_ff) begin
                     mem_cmd.wr_en = in_range;
                     advance       = 1'b1;
                  end
               end
               ata_pkg::PORT_ERROR:   ;
               ata_pkg::PORT_COUNT:   count_in   = wbyte;
               ata_pkg::PORT_LBA_LO:  lba_lo_in  = wbyte;
               ata_pkg::PORT_LBA_MID: lba_mid_in = wbyte;
               ata_pkg::PORT_LBA_HI:  lba_hi_in  = wbyte;
               ata_pkg::PORT_DRIVE:   drive_in   = wbyte;
               default: begin
                  // A command first drops any error and any transfer in progress.
                  err_flag_in = 1'b0;
                  err_reg_in  = ata_pkg::ERR_NONE;
                  drq_in      = 1'b0;
                  writing_in  = 1'b0;
                  word_in     = '0;
                  left_in     = '0;
                  unique case (wbyte) inside
                     ata_pkg::CMD_READ, ata_pkg::CMD_WRITE: begin
                        if (past_end) begin
                           err_flag_in = 1'b1;
                           err_reg_in  = ata_pkg::ERR_IDNF;
                        end else begin
                           cur_in     = CS_W'(lba);
                           left_in    = count_full;
                           drq_in     = 1'b1;
                           writing_in = (wbyte == ata_pkg::CMD_WRITE);
                        end
                     end
                     ata_pkg::CMD_FLUSH: ;
                     default: begin
                        err_flag_in = 1'b1;
                        err_reg_in  = ata_pkg::ERR_ABRT;
                     end
                  endcase
               end
            endcase
         end
      end

      // Step to the next word; the end of a sector moves to the next one.
      if (advance) begin
         word_in = word_ff + WW'(1);
         if (word_ff == {WW{1'b1}}) begin
            cur_in  = cur_ff + CS_W'(1);
            left_in = left_ff - CW'(1);
            if (left_ff == CW'(1)) begin
               drq_in     = 1'b0;
               writing_in = 1'b0;
            end
         end
      end
   end

   // Task-file registers and transfer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         lba_lo_ff   <= '0;
         lba_mid_ff  <= '0;
         lba_hi_ff   <= '0;
         drive_ff    <= '0;
         err_reg_ff  <= '0;
         drq_ff      <= 1'b0;
         err_flag_ff <= 1'b0;
         writing_ff  <= 1'b0;
         cur_ff      <= '0;
         left_ff     <= '0;
         word_ff     <= '0;
      end else begin
         count_ff    <= count_in;
         lba_lo_ff   <= lba_lo_in;
         lba_mid_ff  <= lba_mid_in;
         lba_hi_ff   <= lba_hi_in;
         drive_ff    <= drive_in;
         err_reg_ff  <= err_reg_in;
         drq_ff      <= drq_in;
         err_flag_ff <= err_flag_in;
         writing_ff  <= writing_in;
         cur_ff      <= cur_in;
         left_ff     <= left_in;
         word_ff     <= word_in;
      end
   end

   // A write transfer is always a transfer in progress.
   assert property (@(posedge clock) disable iff (reset) writing_ff |-> drq_ff)
      else $error("write direction set without DRQ");

   // While DRQ is up, sectors remain and the current sector lies inside the store.
   assert property (@(posedge clock) disable iff (reset)
      drq_ff |-> (left_ff != '0) && in_range)
      else $error("transfer state out of range");

   // The error flag always carries a known error code.
   assert property (@(posedge clock) disable iff (reset)
      err_flag_ff |-> (err_reg_ff == ata_pkg::ERR_ABRT) || (err_reg_ff == ata_pkg::ERR_IDNF))
      else $error("error flag without error code");

endmodule

[hw/rtl/ata_pio_lba28_disk_device.sv]
// Result path: an accepted bus access is registered in the first result stage, then in
// the output stage that drives the result port; a stalled result sink holds both stages.
// Throughput: one bus access per cycle unless the result sink stalls; the sector store's
// single port and its registered read set the two-stage result path.
// Reset: synchronous and active high; it clears the task file, the transfer state
// and the result path. The sector store is not cleared and holds stale words.
module ata_pio_lba28_disk_device #(
   parameter int NUM_SECTORS = ata_pkg::NUM_SECTORS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ata_req_if.sink   req_bus,
   ata_rsp_if.source rsp_bus
);

   localparam int DEPTH  = NUM_SECTORS * ata_pkg::WORDS_PER_SECTOR;
   localparam int ADDR_W = $clog2(DEPTH);

   logic                 req_fire;
   logic                 out_free;
   logic                 s1_move;
   logic [15:0]          reg_data;
   logic                 use_mem;
   ata_pkg::mem_cmd_type mem_cmd;
   logic [ADDR_W-1:0]    mem_addr;
   logic [15:0]          mem_wdata;
   logic [15:0]          rd_data;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_mem_ff;
   logic [15:0] s1_data_ff;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_data_ff;

   // Handshake: a new access enters when the first stage is empty or moves on.
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign s1_move       = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || out_free;
   assign req_fire      = req_bus.valid && req_bus.ready;

   ata_task_file #(
      .NUM_SECTORS (NUM_SECTORS),
      .ADDR_W      (ADDR_W)
   ) u_task_file (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_fire),
      .action      (req_bus.action),
      .port_offset (req_bus.port_offset),
      .write_data  (req_bus.write_data),
      .reg_data    (reg_data),
      .use_mem     (use_mem),
      .mem_cmd     (mem_cmd),
      .mem_addr    (mem_addr),
      .mem_wdata   (mem_wdata)
   );

   ata_sector_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_sector_store (
      .clock     (clock),
      .mem_cmd   (mem_cmd),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .rd_data   (rd_data)
   );

   // Valid bits of the two result stages.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload: the register value, or the store's registered read word.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mem_ff  <= use_mem;
         s1_data_ff <= reg_data;
      end
      if (s1_move) begin
         out_data_ff <= s1_mem_ff ? rd_data : s1_data_ff;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.read_data = out_data_ff;

   // A first-stage result that cannot move stays in place.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_data_ff) && $stable(s1_mem_ff))
      else $error("stalled first-stage result lost");

   // A result that waits on the sink keeps its valid and its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(rsp_bus.read_data))
      else $error("stalled result changed");

   // With both stages full and the sink stalled, no new access is taken.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("access taken while the result path is full");

endmodule
